@@ design/moving_average_dc_removal_macros.svh @@
// Assertion macros used by the moving-average DC removal top level.
`ifndef MOVING_AVERAGE_DC_REMOVAL_MACROS_SVH
`define MOVING_AVERAGE_DC_REMOVAL_MACROS_SVH

// Same-cycle implication, checked on rising clk edges outside reset.
`define MADC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on rising clk edges outside reset.
`define MADC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/madc_pkg.sv @@
// Shared widths for the moving-average DC removal block.
`timescale 1ns / 1ps

package madc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RESULT_W = 17;
  localparam int STORE_W  = 2 * SAMPLE_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [RESULT_W-1:0] result_t;

endpackage

@@ design/madc_floor_div.sv @@
// Floor division of a signed window sum by the constant window length.
`timescale 1ns / 1ps

module madc_floor_div
  import madc_pkg::*;
#(
  parameter int WINDOW = 64
) (
  input  logic signed [SAMPLE_W+((WINDOW > 1) ? $clog2(WINDOW) : 0)-1:0] sum,
  output sample_t                                                          quot
);

  localparam int L_W   = (WINDOW > 1) ? $clog2(WINDOW) : 0;
  localparam int SUM_W = SAMPLE_W + L_W;

  generate
    if ((WINDOW & (WINDOW - 1)) == 0) begin : g_shift
      logic signed [SUM_W-1:0] shifted;

      // An arithmetic shift rounds toward minus infinity.
      assign shifted = sum >>> L_W;
      assign quot    = shifted[SAMPLE_W-1:0];
    end else begin : g_recip
      // Magnitude bits of the folded sum, and the reciprocal scale.
      localparam int MAG_W  = SUM_W - 1;
      localparam int SHIFT  = MAG_W + L_W;
      localparam int MULT_W = MAG_W + 2;
      localparam longint unsigned MULT =
        ((64'd1 << SHIFT) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);
      localparam int PROD_W = MAG_W + MULT_W;

      logic                    neg;
      logic [MAG_W-1:0]        mag;
      logic [PROD_W-1:0]       prod;
      logic [SAMPLE_W-2:0]     q_mag;

      // For a negative sum, floor(s / W) equals ~floor(~s / W), so the
      // divider only ever sees a non-negative value.
      assign neg   = sum[SUM_W-1];
      assign mag   = sum[MAG_W-1:0] ^ {MAG_W{neg}};
      assign prod  = PROD_W'(mag) * PROD_W'(MULT_W'(MULT));
      assign q_mag = prod[SHIFT +: (SAMPLE_W-1)];
      assign quot  = {1'b0, q_mag} ^ {SAMPLE_W{neg}};
    end
  endgenerate

endmodule

@@ design/moving_average_dc_removal.sv @@
// Top level of the moving-average DC removal block.
`timescale 1ns / 1ps
// Removes the DC part of a complex sample stream: each input word gives one
// output word equal to the sample minus the floor of the mean of the last
// WINDOW samples, the current one included. Before WINDOW samples have
// arrived, the missing history counts as zero.
// Both channels use valid/ready; a word moves when valid and ready are high
// at the same rising edge. An accepted input word is held in stage one,
// then in stage two, then in the output register that drives out_valid.
// The block takes one word per cycle sustained while out_ready stays high:
// the history memory is read and written once per accepted word.
// Each pipeline stage holds its word until the next stage frees up, so an
// output stall first fills the empty stages and only then drops in_ready.
// No word is lost or repeated under stalls on either side.
// Reset (rst_n low, synchronous) empties the pipeline, clears the running
// sums and the write pointer, and marks the whole history as zero through
// a fill flag; no clearing pass is needed, so words are taken right away.
// Width of the running sums is 16 + clog2(WINDOW) bits.

`include "moving_average_dc_removal_macros.svh"

module moving_average_dc_removal
  import madc_pkg::*;
#(
  parameter int WINDOW = 64
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_sample_re,
  input  sample_t in_sample_im,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result_re,
  output result_t out_result_im
);

  localparam int L_W    = (WINDOW > 1) ? $clog2(WINDOW) : 0;
  localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = SAMPLE_W + L_W;
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW - 1);

  logic [STORE_W-1:0] mem [WINDOW];

  logic [ADDR_W-1:0] slot_r;
  logic [ADDR_W-1:0] slot_nxt;
  logic              filled_r;

  logic               s1_valid_r;
  sample_t            s1_re_r;
  sample_t            s1_im_r;
  logic [STORE_W-1:0] s1_old_r;
  logic               s1_live_r;

  logic    s2_valid_r;
  sample_t s2_re_r;
  sample_t s2_im_r;

  logic signed [SUM_W-1:0] sum_re_r;
  logic signed [SUM_W-1:0] sum_im_r;
  logic signed [SUM_W-1:0] sum_re_nxt;
  logic signed [SUM_W-1:0] sum_im_nxt;

  logic    out_valid_r;
  result_t out_re_r;
  result_t out_im_r;
  result_t out_re_nxt;
  result_t out_im_nxt;

  sample_t old_re;
  sample_t old_im;
  sample_t quot_re;
  sample_t quot_im;

  logic en_out;
  logic en2;
  logic en1;
  logic in_fire;

  // Each stage loads when it is empty or its word moves on.
  assign en_out  = !out_valid_r || out_ready;
  assign en2     = !s2_valid_r || en_out;
  assign en1     = !s1_valid_r || en2;
  assign in_ready = en1;
  assign in_fire  = in_valid && en1;

  assign slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;

  // History memory: the oldest word is read out as the new one replaces it.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_old_r     <= mem[slot_r];
      mem[slot_r]  <= {in_sample_im, in_sample_re};
    end
  end

  // Entries never written since reset hold zero in the model of the window.
  assign old_re = s1_live_r ? s1_old_r[SAMPLE_W-1:0]       : '0;
  assign old_im = s1_live_r ? s1_old_r[STORE_W-1:SAMPLE_W] : '0;

  assign sum_re_nxt = sum_re_r + SUM_W'(s1_re_r) - SUM_W'(old_re);
  assign sum_im_nxt = sum_im_r + SUM_W'(s1_im_r) - SUM_W'(old_im);

  madc_floor_div #(.WINDOW(WINDOW)) u_div_re (
    .sum  (sum_re_r),
    .quot (quot_re)
  );

  madc_floor_div #(.WINDOW(WINDOW)) u_div_im (
    .sum  (sum_im_r),
    .quot (quot_im)
  );

  assign out_re_nxt = RESULT_W'(s2_re_r) - RESULT_W'(quot_re);
  assign out_im_nxt = RESULT_W'(s2_im_r) - RESULT_W'(quot_im);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      filled_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sum_re_r    <= '0;
      sum_im_r    <= '0;
    end else begin
      if (in_fire) begin
        slot_r <= slot_nxt;
        if (slot_r == LAST_SLOT) begin
          filled_r <= 1'b1;
        end
      end
      if (en1) begin
        s1_valid_r <= in_valid;
      end
      if (en2) begin
        s2_valid_r <= s1_valid_r;
        // The sums always belong to the word that sits in stage two.
        if (s1_valid_r) begin
          sum_re_r <= sum_re_nxt;
          sum_im_r <= sum_im_nxt;
        end
      end
      if (en_out) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_re_r   <= in_sample_re;
      s1_im_r   <= in_sample_im;
      s1_live_r <= filled_r;
    end
    if (en2 && s1_valid_r) begin
      s2_re_r <= s1_re_r;
      s2_im_r <= s1_im_r;
    end
    if (en_out && s2_valid_r) begin
      out_re_r <= out_re_nxt;
      out_im_r <= out_im_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result_re = out_re_r;
  assign out_result_im = out_im_r;

  `MADC_ASSERT_NEXT(a_fill_after_wrap, in_fire && (slot_r == LAST_SLOT), filled_r,
    "history fill flag not set after the pointer wrapped")
  `MADC_ASSERT_NOW(a_ready_when_out_free, !out_valid_r, in_ready,
    "input stalled although the output register is free")
  `MADC_ASSERT_NEXT(a_stage1_holds, s1_valid_r && !en2, s1_valid_r,
    "stage one word dropped while stage two was blocked")
  `MADC_ASSERT_NOW(a_sum_re_range,
    1'b1,
    (sum_re_r >= -(SUM_W+1)'(WINDOW * 32768)) && (sum_re_r <= (SUM_W+1)'(WINDOW * 32767)),
    "real running sum left the window range")

endmodule

@@ dv/moving_average_dc_removal_checker.sv @@
// Checker for the moving-average DC removal block: predicts and compares output words.
`timescale 1ns / 1ps

module moving_average_dc_removal_checker
  import madc_pkg::*;
#(
  parameter int WINDOW = 64
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_ready,
  input  sample_t in_sample_re,
  input  sample_t in_sample_im,
  input  logic    out_valid,
  input  logic    out_ready,
  input  result_t out_result_re,
  input  result_t out_result_im,
  output int      fail_count,
  output int      words_due
);

  typedef struct {
    result_t re;
    result_t im;
  } dc_free_t;

  sample_t  hist_re [WINDOW];
  sample_t  hist_im [WINDOW];
  int       oldest_slot;
  int       window_sum_re;
  int       window_sum_im;
  dc_free_t dc_free_q[$];
  int       mismatches = 0;

  // Window mean rounded toward minus infinity.
  function automatic int floor_mean(input int total);
    int q;
    q = total / WINDOW;
    if (total % WINDOW != 0 && total < 0) begin
      q -= 1;
    end
    return q;
  endfunction

  always @(posedge clk) begin
    dc_free_t want;
    dc_free_t got;
    if (!rst_n) begin
      for (int k = 0; k < WINDOW; k++) begin
        hist_re[k] = '0;
        hist_im[k] = '0;
      end
      oldest_slot   = 0;
      window_sum_re = 0;
      window_sum_im = 0;
      dc_free_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        window_sum_re = window_sum_re + int'(in_sample_re) - int'(hist_re[oldest_slot]);
        window_sum_im = window_sum_im + int'(in_sample_im) - int'(hist_im[oldest_slot]);
        hist_re[oldest_slot] = in_sample_re;
        hist_im[oldest_slot] = in_sample_im;
        oldest_slot = (oldest_slot == WINDOW - 1) ? 0 : oldest_slot + 1;
        want.re = result_t'(int'(in_sample_re) - floor_mean(window_sum_re));
        want.im = result_t'(int'(in_sample_im) - floor_mean(window_sum_im));
        dc_free_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (dc_free_q.size() == 0) begin
          mismatches++;
          $display("%0t: output word with none expected: re %0d im %0d",
                   $time, out_result_re, out_result_im);
        end else begin
          got = dc_free_q.pop_front();
          if (got.re !== out_result_re) begin
            mismatches++;
            $display("%0t: result_re expected %0d actual %0d", $time, got.re, out_result_re);
          end
          if (got.im !== out_result_im) begin
            mismatches++;
            $display("%0t: result_im expected %0d actual %0d", $time, got.im, out_result_im);
          end
        end
      end
    end
    words_due  <= dc_free_q.size();
    fail_count <= mismatches;
  end

endmodule

@@ dv/moving_average_dc_removal_test.sv @@
// Top of the moving-average DC removal testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module moving_average_dc_removal_test
  import madc_pkg::*;
();

  localparam int WINDOW      = 64;
  localparam int PHASE_WORDS = 350;
  localparam int QUIET_LIMIT = 5000;

  typedef enum {SEG_UNIFORM, SEG_RAIL, SEG_TINY, SEG_OFFSET} seg_kind_t;

  logic    clk;
  logic    rst_n         = 1'b0;
  logic    in_valid      = 1'b0;
  logic    in_ready;
  sample_t in_sample_re  = '0;
  sample_t in_sample_im  = '0;
  logic    out_valid;
  logic    out_ready     = 1'b0;
  result_t out_result_re;
  result_t out_result_im;

  int fail_count;
  int words_due;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;

  moving_average_dc_removal #(.WINDOW(WINDOW)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_re  (in_sample_re),
    .in_sample_im  (in_sample_im),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_result_re (out_result_re),
    .out_result_im (out_result_im)
  );

  moving_average_dc_removal_checker #(.WINDOW(WINDOW)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_re  (in_sample_re),
    .in_sample_im  (in_sample_im),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_result_re (out_result_re),
    .out_result_im (out_result_im),
    .fail_count    (fail_count),
    .words_due     (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("moving_average_dc_removal_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Valid stays high from one word to the next unless an idle cycle is drawn.
  task automatic send_word(input sample_t re, input sample_t im);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_re <= re;
    in_sample_im <= im;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    int        idle_of_phase [4];
    int        stall_of_phase [4];
    int        phase_words;
    int        seg_len;
    int        dc_re;
    int        dc_im;
    seg_kind_t kind;
    sample_t   rail_re;
    sample_t   rail_im;
    sample_t   re;
    sample_t   im;

    idle_of_phase  = '{0, 64, 0, 17};
    stall_of_phase = '{0, 0, 64, 17};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words during start-up: rails, sign edges, alternating bits,
    // then a run at each rail so the sum swings hard.
    send_word(16'sh0000, 16'sh0000);
    send_word(16'sh7fff, 16'sh8000);
    send_word(16'sh8000, 16'sh7fff);
    send_word(16'shffff, 16'sh0001);
    send_word(16'sh0001, 16'shffff);
    send_word(16'sh5555, 16'shaaaa);
    send_word(16'shaaaa, 16'sh5555);
    repeat (8) send_word(16'sh7fff, 16'sh7fff);
    repeat (8) send_word(16'sh8000, 16'sh8000);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_of_phase[phase];
      stall_pct    <= stall_of_phase[phase];
      phase_words   = 0;
      while (phase_words < PHASE_WORDS) begin
        kind    = seg_kind_t'($urandom_range(0, 3));
        seg_len = $urandom_range(1, 150);
        rail_re = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        rail_im = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        dc_re   = int'($urandom_range(0, 64000)) - 32000;
        dc_im   = int'($urandom_range(0, 64000)) - 32000;
        for (int n = 0; n < seg_len && phase_words < PHASE_WORDS; n++) begin
          case (kind)
            SEG_UNIFORM: begin
              re = sample_t'($urandom);
              im = sample_t'($urandom);
            end
            SEG_RAIL: begin
              // Long holds at a rail fill the window with the extreme value.
              if ($urandom_range(0, 63) == 0) rail_re = ~rail_re;
              if ($urandom_range(0, 63) == 0) rail_im = ~rail_im;
              re = rail_re;
              im = rail_im;
            end
            SEG_TINY: begin
              // Small values around zero exercise rounding of negative sums.
              re = sample_t'(int'($urandom_range(0, 16)) - 8);
              im = sample_t'(int'($urandom_range(0, 16)) - 8);
            end
            default: begin
              re = sample_t'(dc_re + int'($urandom_range(0, 1000)) - 500);
              im = sample_t'(dc_im + int'($urandom_range(0, 1000)) - 500);
            end
          endcase
          send_word(re, im);
          phase_words++;
        end
      end
    end

    in_valid  <= 1'b0;
    stall_pct <= 0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("moving_average_dc_removal_test OK");
    end else begin
      $display("moving_average_dc_removal_test NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/madc_pkg.sv
design/madc_floor_div.sv
design/moving_average_dc_removal.sv
dv/moving_average_dc_removal_checker.sv
dv/moving_average_dc_removal_test.sv
